### sv/sliding_rms_agc_gain_macros.svh
// Assertion macros shared by the checker of the sliding RMS gain block.
// Depends on nothing; included by the files that assert.
`ifndef SLIDING_RMS_AGC_GAIN_MACROS_SVH
`define SLIDING_RMS_AGC_GAIN_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SRAGC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sragc check failed");

// Property checked at every clock edge, reset included.
`define SRAGC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("sragc reset check failed");

`endif

### sv/sragc_pkg.sv
// Types and constants for the sliding RMS gain block.
// Used by every module of the block but the queue; depends on nothing.
`timescale 1ns / 1ps

package sragc_pkg;

   localparam int DEF_HALF_WINDOW = 32;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 32;
   localparam int PRESCALE_W = 16;
   localparam int SEEN_W     = 16;

   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd256;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       trace_end;
   } req_item_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic              gain_last;
   } rsp_item_type;

endpackage

### sv/sliding_rms_agc_gain.sv
// Channel   Ports                            Payload
// req       req_valid / req_stall            req_item: sample, trace_end
// rsp       rsp_valid / rsp_stall            rsp_item: gain, gain_last
// csr       csr_wr_en / csr_wr_data          prescale, Q8.8
//
// The front takes a sample through its idle, update and emit states and
// queues window jobs; a trace end adds a read and a drop state per flushed
// gain. The back computes each gain by a mean divide (2 bits a cycle),
// a square root (1 root bit a cycle), one multiply and a gain divide
// (1 bit a cycle). Reset is synchronous and empties both parts; a stalled
// output holds its item while the back finishes the next one.
`timescale 1ns / 1ps

module sliding_rms_agc_gain import sragc_pkg::*; #(
   parameter int HALF_WINDOW = DEF_HALF_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [PRESCALE_W-1:0] csr_wr_data
);

   localparam int DEPTH = 2 * HALF_WINDOW + 1;
   localparam int E_W   = 2 * SAMPLE_BITS - 2 + $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int JOB_W = E_W + CNT_W + 1;

   logic [PRESCALE_W-1:0] prescale_ff;
   logic                  job_push, job_full, job_pop, job_valid;
   logic [JOB_W-1:0]      push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_RESET;
      end else if (csr_wr_en) begin
         prescale_ff <= csr_wr_data;
      end
   end

   sragc_front #(
      .HALF_WINDOW(HALF_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .job_push (job_push),
      .job_data (push_data),
      .job_full (job_full)
   );

   sragc_queue #(
      .WIDTH(JOB_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data(push_data),
      .full     (job_full),
      .pop      (job_pop),
      .pop_valid(job_valid),
      .pop_data (pop_data)
   );

   sragc_back #(
      .HALF_WINDOW(HALF_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .prescale (prescale_ff),
      .job_valid(job_valid),
      .job_data (pop_data),
      .job_pop  (job_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

endmodule

### sv/sragc_queue.sv
// Small show-ahead queue of window jobs between front and back.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module sragc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [AW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == CW'(DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = slot_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

### sv/sragc_front.sv
// Front end: takes samples, keeps the window of squares and its energy,
// and issues one window job per gain, including the end-of-trace flush.
// Depends on sragc_pkg.
`timescale 1ns / 1ps

module sragc_front import sragc_pkg::*; #(
   parameter int HALF_WINDOW = DEF_HALF_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int DEPTH = 2 * HALF_WINDOW + 1,
   localparam int E_W   = 2 * SAMPLE_BITS - 2 + $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int JOB_W = E_W + CNT_W + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_item_type     req_item,
   output logic             job_push,
   output logic [JOB_W-1:0] job_data,
   input  logic             job_full
);

   localparam int PW   = $clog2(DEPTH);
   localparam int SQ_W = 2 * SAMPLE_BITS - 1;
   localparam int TW   = $clog2(HALF_WINDOW + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_UPD   = 3'd1;
   localparam logic [2:0] S_EMIT  = 3'd2;
   localparam logic [2:0] S_FRD   = 3'd3;
   localparam logic [2:0] S_FDROP = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic              last_ff, last_in;
   logic              emit_ff, emit_in;
   logic [E_W-1:0]    energy_ff, energy_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [PW-1:0]     wptr_ff, wptr_in;
   logic [TW-1:0]     t_ff, t_in;
   logic [TW-1:0]     nflush_ff, nflush_in;
   logic [SQ_W-1:0]   rd_ff;
   logic [SQ_W-1:0]   line_mem [DEPTH];

   logic                   accept;
   logic [SAMPLE_BITS-1:0] raw, mag;
   logic [2*SAMPLE_BITS-1:0] prod;
   logic [PW:0]            slot_sum;
   logic [PW-1:0]          slot, rd_addr;
   logic                   mem_we;
   logic                   full_win, drop, t_last;
   logic [E_W-1:0]         energy_drop;
   logic [CNT_W-1:0]       count_drop;
   logic [SEEN_W-1:0]      seen_next;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign raw  = SAMPLE_BITS'(req_item.sample);
   assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign prod = mag * mag;

   assign slot_sum = {1'b0, wptr_ff} + (PW+1)'(t_ff);
   assign slot     = (slot_sum >= (PW+1)'(DEPTH)) ? PW'(slot_sum - (PW+1)'(DEPTH))
                                                  : PW'(slot_sum);
   assign rd_addr  = (state_ff == S_FRD || state_ff == S_FDROP) ? slot : wptr_ff;

   assign full_win  = (seen_ff >= SEEN_W'(DEPTH));
   assign seen_next = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
   assign drop      = ((SEEN_W+1)'(seen_ff) + (SEEN_W+1)'(t_ff)) >= (SEEN_W+1)'(DEPTH);
   assign t_last    = ((t_ff + TW'(1)) == nflush_ff);

   assign energy_drop = drop ? energy_ff - E_W'(rd_ff) : energy_ff;
   assign count_drop  = (drop && count_ff != '0) ? count_ff - 1'b1 : count_ff;

   always_comb begin
      state_in  = state_ff;
      sq_in     = sq_ff;
      last_in   = last_ff;
      emit_in   = emit_ff;
      energy_in = energy_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      wptr_in   = wptr_ff;
      t_in      = t_ff;
      nflush_in = nflush_ff;
      mem_we    = 1'b0;
      job_push  = 1'b0;
      job_data  = {energy_ff, count_ff, 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sq_in    = SQ_W'(prod);
               last_in  = req_item.trace_end;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            // rd_ff holds the oldest square, read when the item came in
            energy_in = (full_win ? energy_ff - E_W'(rd_ff) : energy_ff) + E_W'(sq_ff);
            count_in  = full_win ? count_ff : count_ff + 1'b1;
            mem_we    = 1'b1;
            wptr_in   = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
            seen_in   = seen_next;
            emit_in   = (seen_ff >= SEEN_W'(HALF_WINDOW));
            nflush_in = (seen_next < SEEN_W'(HALF_WINDOW)) ? TW'(seen_next)
                                                           : TW'(HALF_WINDOW);
            t_in      = '0;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (!emit_ff || !job_full) begin
               job_push = emit_ff;
               state_in = last_ff ? S_FRD : S_IDLE;
            end
         end
         S_FRD: begin
            state_in = S_FDROP;
         end
         S_FDROP: begin
            job_data = {energy_drop, count_drop, t_last};
            if (!job_full) begin
               job_push  = 1'b1;
               energy_in = energy_drop;
               count_in  = count_drop;
               t_in      = t_ff + 1'b1;
               state_in  = S_FRD;
               if (t_last) begin
                  // trace done: start the next one from empty
                  energy_in = '0;
                  count_in  = '0;
                  seen_in   = '0;
                  wptr_in   = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         energy_ff <= '0;
         count_ff  <= '0;
         seen_ff   <= '0;
         wptr_ff   <= '0;
         t_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         energy_ff <= energy_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
         wptr_ff   <= wptr_in;
         t_ff      <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      last_ff   <= last_in;
      emit_ff   <= emit_in;
      nflush_ff <= nflush_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[wptr_ff] <= sq_ff;
      end
      rd_ff <= line_mem[rd_addr];
   end

endmodule

### sv/sragc_back.sv
// Back end: turns one window job into a gain with a serial divide,
// a serial square root, one multiply and a second serial divide.
// Depends on sragc_pkg.
`timescale 1ns / 1ps

module sragc_back import sragc_pkg::*; #(
   parameter int HALF_WINDOW = DEF_HALF_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int DEPTH = 2 * HALF_WINDOW + 1,
   localparam int E_W   = 2 * SAMPLE_BITS - 2 + $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int JOB_W = E_W + CNT_W + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [PRESCALE_W-1:0] prescale,
   input  logic                  job_valid,
   input  logic [JOB_W-1:0]      job_data,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item
);

   localparam int RF   = (57 - 2 * SAMPLE_BITS) / 2;
   localparam int NW   = E_W + 2 * RF;
   localparam int NWP  = NW + (NW % 2);
   localparam int RW   = NWP / 2;
   localparam int DW   = PRESCALE_W + RW;
   localparam logic [63:0] GAIN_NUM = ((64'd1 << (24 + RF)) * 64'd4 + 64'd5) / 64'd10;
   localparam int GW   = $clog2(GAIN_NUM + 64'd1);
   localparam int ITER_MAX = (GW > RW) ? GW : RW;
   localparam int IW   = $clog2(ITER_MAX + 1);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_DIV1 = 3'd1;
   localparam logic [2:0] B_SQRT = 3'd2;
   localparam logic [2:0] B_MUL  = 3'd3;
   localparam logic [2:0] B_DIV2 = 3'd4;
   localparam logic [2:0] B_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [NWP-1:0]    num_ff, num_in;
   logic [CNT_W-1:0]  rem1_ff, rem1_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [IW-1:0]     iter_ff, iter_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [RW+1:0]     srem_ff, srem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [GW-1:0]     q2_ff, q2_in;
   logic [DW-1:0]     rem2_ff, rem2_in;
   logic [GAIN_W-1:0] res_ff, res_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic [E_W-1:0]   job_energy;
   logic [CNT_W-1:0] job_count;
   logic             out_free;

   assign job_energy = job_data[JOB_W-1 -: E_W];
   assign job_count  = job_data[1 +: CNT_W];
   assign job_pop    = (state_ff == B_IDLE) && job_valid;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   always_comb begin
      logic [CNT_W:0]  t1;
      logic [CNT_W-1:0] r1;
      logic [NWP-1:0]  n1;
      logic [RW+3:0]   st;
      logic [RW+3:0]   trial;
      logic [DW:0]     t2;
      logic            qb;
      state_in     = state_ff;
      num_in       = num_ff;
      rem1_in      = rem1_ff;
      dvs_in       = dvs_ff;
      iter_in      = iter_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      den_in       = den_ff;
      q2_in        = q2_ff;
      rem2_in      = rem2_ff;
      res_in       = res_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      r1           = rem1_ff;
      n1           = num_ff;
      t1           = '0;
      st           = '0;
      trial        = '0;
      t2           = '0;
      qb           = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               last_in = job_data[0];
               if (job_energy == '0 || job_count == '0) begin
                  res_in   = '0;
                  state_in = B_DONE;
               end else begin
                  num_in   = NWP'(job_energy) << (2 * RF);
                  rem1_in  = '0;
                  dvs_in   = job_count;
                  iter_in  = IW'(RW);
                  state_in = B_DIV1;
               end
            end
         end
         B_DIV1: begin
            // two quotient bits per cycle of the mean
            for (int k = 0; k < 2; k++) begin
               t1 = {r1, n1[NWP-1]};
               if (t1 >= {1'b0, dvs_ff}) begin
                  r1 = CNT_W'(t1 - {1'b0, dvs_ff});
                  qb = 1'b1;
               end else begin
                  r1 = CNT_W'(t1);
                  qb = 1'b0;
               end
               n1 = {n1[NWP-2:0], qb};
            end
            num_in  = n1;
            rem1_in = r1;
            iter_in = iter_ff - 1'b1;
            if (iter_ff == IW'(1)) begin
               root_in  = '0;
               srem_in  = '0;
               iter_in  = IW'(RW);
               state_in = B_SQRT;
            end
         end
         B_SQRT: begin
            st    = {srem_ff, num_ff[NWP-1 -: 2]};
            trial = (RW+4)'({root_ff, 2'b01});
            if (st >= trial) begin
               srem_in = (RW+2)'(st - trial);
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               srem_in = (RW+2)'(st);
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            num_in  = num_ff << 2;
            iter_in = iter_ff - 1'b1;
            if (iter_ff == IW'(1)) begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            den_in   = DW'(prescale) * DW'(root_ff);
            q2_in    = GW'(GAIN_NUM);
            rem2_in  = '0;
            iter_in  = IW'(GW);
            state_in = B_DIV2;
         end
         B_DIV2: begin
            t2 = {rem2_ff, q2_ff[GW-1]};
            if (t2 >= {1'b0, den_ff}) begin
               rem2_in = DW'(t2 - {1'b0, den_ff});
               qb      = 1'b1;
            end else begin
               rem2_in = DW'(t2);
               qb      = 1'b0;
            end
            q2_in   = {q2_ff[GW-2:0], qb};
            iter_in = iter_ff - 1'b1;
            if (iter_ff == IW'(1)) begin
               // zero prescale gives zero gain; saturate the rest
               if (den_ff == '0) begin
                  res_in = '0;
               end else if (64'({q2_ff[GW-2:0], qb}) > 64'hFFFF_FFFF) begin
                  res_in = '1;
               end else begin
                  res_in = GAIN_W'({q2_ff[GW-2:0], qb});
               end
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_item_in.gain      = res_ff;
               rsp_item_in.gain_last = last_ff;
               state_in              = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      rem1_ff     <= rem1_in;
      dvs_ff      <= dvs_in;
      iter_ff     <= iter_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      den_ff      <= den_in;
      q2_ff       <= q2_in;
      rem2_ff     <= rem2_in;
      res_ff      <= res_in;
      last_ff     <= last_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

### sv/sragc_checker.sv
// Port-level checks for the sliding RMS gain block, bound to the top level.
// Depends on sragc_pkg and sliding_rms_agc_gain_macros.svh.
`timescale 1ns / 1ps
`include "sliding_rms_agc_gain_macros.svh"

module sragc_checker import sragc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   `SRAGC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid)
   `SRAGC_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_item))
   `SRAGC_ASSERT(a_req_busy, req_valid && !req_stall |=> req_stall)
   `SRAGC_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid && !req_stall)

endmodule

bind sliding_rms_agc_gain sragc_checker u_sragc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_item (rsp_item)
);
